FILE: sv/msm_pkg.sv
// ---------------------------------------------------------------------------
// msm_pkg
// Shared constants and types for the multi-pattern substring match unit.
// ---------------------------------------------------------------------------
package msm_pkg;

  // table geometry
  localparam int MAX_RULES       = 64;
  localparam int MAX_PATTERN_LEN = 16;
  localparam int MIN_LEN         = 3;

  // field widths
  localparam int RULE_W   = $clog2(MAX_RULES);
  localparam int CNT_W    = $clog2(MAX_RULES + 1);
  localparam int CPOS_W   = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W    = 5;
  localparam int ACT_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int BPOS_W   = 16;
  localparam int RCOUNT_W = 7;

  // tie groups by low index bits
  localparam int TIE_W = 3;

  // kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  // saturation limit for byte positions
  localparam logic [BPOS_W-1:0] POS_LIMIT = {BPOS_W{1'b1}};

  // one pattern word: byte i of the pattern at index i
  typedef logic [MAX_PATTERN_LEN-1:0][CHAR_W-1:0] pat_word_t;

  // write request into the pattern memory
  typedef struct packed {
    logic              en;
    logic [RULE_W-1:0] rule;
    logic [CPOS_W-1:0] pos;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic [ACT_W-1:0]  act;
  } wr_req_t;

  // outcome of checking one pattern against the byte window
  typedef struct packed {
    logic              hit;
    logic [BPOS_W-1:0] start;
  } eval_t;

endpackage

FILE: sv/msm_pattern_ram.sv
// ---------------------------------------------------------------------------
// msm_pattern_ram
// Pattern table: one byte-lane write and one registered word read per cycle.
// ---------------------------------------------------------------------------
module msm_pattern_ram (
  input  logic                      clk,
  input  msm_pkg::wr_req_t          wr,
  input  logic [msm_pkg::RULE_W-1:0] raddr,
  output msm_pkg::pat_word_t        rd_pat,
  output logic [msm_pkg::LEN_W-1:0] rd_len,
  output logic [msm_pkg::ACT_W-1:0] rd_act
);

  msm_pkg::pat_word_t pat_mem [msm_pkg::MAX_RULES];
  logic [msm_pkg::LEN_W+msm_pkg::ACT_W-1:0] meta_mem [msm_pkg::MAX_RULES];

  // byte lane write plus length and action
  always_ff @(posedge clk) begin
    if (wr.en) begin
      pat_mem[wr.rule][wr.pos] <= wr.ch;
      meta_mem[wr.rule]        <= {wr.len, wr.act};
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_pat           <= pat_mem[raddr];
    {rd_len, rd_act} <= meta_mem[raddr];
  end

endmodule

FILE: sv/msm_match_eval.sv
// ---------------------------------------------------------------------------
// msm_match_eval
// Compares one stored pattern with the most recent string bytes.
// ---------------------------------------------------------------------------
module msm_match_eval (
  input  msm_pkg::pat_word_t         pat,
  input  logic [msm_pkg::LEN_W-1:0]  len,
  input  msm_pkg::pat_word_t         window,
  input  logic [msm_pkg::BPOS_W-1:0] byte_pos,
  output msm_pkg::eval_t             result
);

  logic [msm_pkg::LEN_W-1:0] len_m1;
  logic                      len_ok;
  logic                      bytes_eq;
  logic [msm_pkg::LEN_W-1:0] widx;

  // length range and enough string bytes seen
  always_comb begin
    len_m1 = len - msm_pkg::LEN_W'(1);
    len_ok = (len >= msm_pkg::LEN_W'(msm_pkg::MIN_LEN)) &&
             (len <= msm_pkg::LEN_W'(msm_pkg::MAX_PATTERN_LEN)) &&
             ({{(msm_pkg::BPOS_W-msm_pkg::LEN_W){1'b0}}, len_m1} <= byte_pos);
  end

  // pattern byte i sits len-1-i bytes back in the window
  always_comb begin
    bytes_eq = 1'b1;
    widx     = '0;
    for (int i = 0; i < msm_pkg::MAX_PATTERN_LEN; i++) begin
      widx = len_m1 - msm_pkg::LEN_W'(i);
      if (msm_pkg::LEN_W'(i) < len) begin
        if (pat[i] != window[widx[msm_pkg::CPOS_W-1:0]]) begin
          bytes_eq = 1'b0;
        end
      end
    end
  end

  assign result.hit   = len_ok && bytes_eq;
  assign result.start = byte_pos - {{(msm_pkg::BPOS_W-msm_pkg::LEN_W){1'b0}}, len_m1};

endmodule

FILE: sv/multi_pattern_substring_match_unit.sv
// A load transfer is accepted whenever the unit is idle; a string byte holds the input while
// the table is read once for each of N = min(rule_count, 64) patterns, then a compare and a close.
// A final string byte also posts the result, which waits while the output stalls.
// With the single table read port, a new string byte is taken only once the last one's scan ends.
// Reset clears the string state, rule_count and the output; the pattern table
// holds no reset value and must be loaded before use.
// ---------------------------------------------------------------------------
// multi_pattern_substring_match_unit
// Streams string bytes against a loaded pattern table and reports the
// earliest-starting match on the final byte.
// ---------------------------------------------------------------------------
module multi_pattern_substring_match_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msm_pkg::RCOUNT_W-1:0]  cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [msm_pkg::RULE_W-1:0]    rule_index,
  input  logic [msm_pkg::CPOS_W-1:0]    char_pos,
  input  logic [msm_pkg::CHAR_W-1:0]    pattern_char,
  input  logic [msm_pkg::LEN_W-1:0]     rule_length,
  input  logic [msm_pkg::ACT_W-1:0]     rule_action,
  input  logic [msm_pkg::CHAR_W-1:0]    text_char,
  input  logic                          last_byte,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          matched,
  output logic [msm_pkg::RULE_W-1:0]    rule_number,
  output logic [msm_pkg::ACT_W-1:0]     action,
  output logic [msm_pkg::BPOS_W-1:0]    match_start
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                       state;
  logic [msm_pkg::RCOUNT_W-1:0]     rule_count;
  logic [msm_pkg::CNT_W-1:0]        active;
  logic [msm_pkg::CNT_W-1:0]        scan_cnt;
  logic                             issue;
  logic                             rd_valid;
  logic [msm_pkg::RULE_W-1:0]       rd_rule;
  logic                             last_pend;
  msm_pkg::pat_word_t               window;
  logic [msm_pkg::BPOS_W-1:0]       byte_pos;
  logic                             best_valid;
  logic [msm_pkg::BPOS_W-1:0]       best_start;
  logic [msm_pkg::RULE_W-1:0]       best_rule;
  logic [msm_pkg::ACT_W-1:0]        best_action;
  logic                             in_xfer;
  logic                             out_free;
  logic                             beats;
  msm_pkg::wr_req_t                 wr;
  msm_pkg::pat_word_t               rd_pat;
  logic [msm_pkg::LEN_W-1:0]        rd_len;
  logic [msm_pkg::ACT_W-1:0]        rd_act;
  msm_pkg::eval_t                   ev;

  // handshake
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // patterns taking part
  assign active = (rule_count > msm_pkg::RCOUNT_W'(msm_pkg::MAX_RULES)) ?
                  msm_pkg::CNT_W'(msm_pkg::MAX_RULES) :
                  msm_pkg::CNT_W'(rule_count);
  assign issue  = (state == S_SCAN) && (scan_cnt < active);

  // load path into the table
  always_comb begin
    wr.en   = in_xfer && (kind == msm_pkg::KIND_LOAD);
    wr.rule = rule_index;
    wr.pos  = char_pos;
    wr.ch   = pattern_char;
    wr.len  = rule_length;
    wr.act  = rule_action;
  end

  msm_pattern_ram u_ram (
    .clk    (clk),
    .wr     (wr),
    .raddr  (scan_cnt[msm_pkg::RULE_W-1:0]),
    .rd_pat (rd_pat),
    .rd_len (rd_len),
    .rd_act (rd_act)
  );

  msm_match_eval u_eval (
    .pat      (rd_pat),
    .len      (rd_len),
    .window   (window),
    .byte_pos (byte_pos),
    .result   (ev)
  );

  // winner ordering: earliest start, then low index bits, then index
  always_comb begin
    if (!best_valid || (ev.start < best_start)) begin
      beats = 1'b1;
    end else if (ev.start != best_start) begin
      beats = 1'b0;
    end else if (rd_rule[msm_pkg::TIE_W-1:0] != best_rule[msm_pkg::TIE_W-1:0]) begin
      beats = rd_rule[msm_pkg::TIE_W-1:0] < best_rule[msm_pkg::TIE_W-1:0];
    end else begin
      beats = rd_rule < best_rule;
    end
  end

  // control, window and best match
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rule_count  <= '0;
      scan_cnt    <= '0;
      rd_valid    <= 1'b0;
      last_pend   <= 1'b0;
      window      <= '0;
      byte_pos    <= '0;
      best_valid  <= 1'b0;
      best_start  <= '0;
      best_rule   <= '0;
      best_action <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rule_count <= cfg_data;
      end
      // result transfer frees the output unless a new one is posted
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      // table read in flight
      rd_valid <= issue;
      rd_rule  <= scan_cnt[msm_pkg::RULE_W-1:0];

      if (rd_valid && ev.hit && beats) begin
        best_valid  <= 1'b1;
        best_start  <= ev.start;
        best_rule   <= rd_rule;
        best_action <= rd_act;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer && (kind == msm_pkg::KIND_TEXT)) begin
            window    <= {window[msm_pkg::MAX_PATTERN_LEN-2:0], text_char};
            scan_cnt  <= '0;
            last_pend <= last_byte;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_cnt <= scan_cnt + msm_pkg::CNT_W'(1);
          end else if (!rd_valid) begin
            if (byte_pos != msm_pkg::POS_LIMIT) begin
              byte_pos <= byte_pos + msm_pkg::BPOS_W'(1);
            end
            state <= last_pend ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            matched     <= best_valid;
            rule_number <= best_valid ? best_rule : '0;
            action      <= best_valid ? best_action : '0;
            match_start <= best_valid ? best_start : '0;
            // clear string state
            window      <= '0;
            byte_pos    <= '0;
            best_valid  <= 1'b0;
            best_start  <= '0;
            best_rule   <= '0;
            best_action <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // reads only address active patterns
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ({1'b0, rd_rule} < active))
    else $error("table read beyond active pattern count");

  // no read outstanding while idle
  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_valid)
    else $error("table read pending in idle");

  // scan counter never passes the active count
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_cnt <= active))
    else $error("scan counter overran");

  // posting a result clears the string state
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && out_free) |=> (out_valid && (byte_pos == '0) && !best_valid))
    else $error("result posted without string clear");

endmodule
